// File: rtl/ppt_pkg.sv
// Package for the piece priority table: field widths, operation, status and
// state codes, priority constants and the result record.
// Used by ppt_div and piece_priority_table; depends on nothing.
`default_nettype none

package ppt_pkg;

  localparam int unsigned PSIZE_W = 25;
  localparam int unsigned PIECE_W = 40;
  localparam int unsigned LEN_W   = 40;
  localparam int unsigned FIDX_W  = 8;
  localparam int unsigned PRI_W   = 2;

  localparam logic [PSIZE_W-1:0] PSIZE_RESET = 25'd262144;

  localparam logic [PRI_W-1:0] PRI_LOW    = 2'd0;
  localparam logic [PRI_W-1:0] PRI_NORMAL = 2'd1;
  localparam logic [PRI_W-1:0] PRI_HIGH   = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SET_PRI = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WALK,
    S_FINISH
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [PRI_W-1:0]     ppri;
    logic [PIECE_W-1:0]   first_piece;
    logic [PIECE_W-1:0]   last_piece;
    logic [FIDX_W-1:0]    aidx;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/piece_priority_table.sv
// Piece priority table top level: item FSM, file entry memories and query walk.
// Depends on ppt_pkg and ppt_div.
//
//   channel   direction  handshake                  payload
//   in        sink       in_valid_i / in_ready_o    operation_i .. piece_index_i
//   out       source     out_valid_o / out_ready_i  status_o .. assigned_index_o
//   cfg       sink       cfg_valid_i / cfg_ready_o  cfg_piece_size_i
//
// One item is in work at a time. Clear, set and error outcomes pass from
// S_EXEC to S_FINISH and a result beat; an append waits in S_DIV on the
// bit-serial dividers for the first and last piece; a query walks the
// entries in S_WALK, at most one memory read per stored entry.
// Reset needs no clearing pass: only entries below the count are ever read.
// A result waits in the output register while the next item is accepted; the
// FSM holds a finished result only when that register is still occupied.
`default_nettype none

module piece_priority_table
  import ppt_pkg::*;
#(
  parameter int unsigned MAX_FILES   = 256,
  parameter int unsigned OFFSET_BITS = 40
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [LEN_W-1:0]   file_length_i,
  input  wire logic [PRI_W-1:0]   file_priority_i,
  input  wire logic [FIDX_W-1:0]  file_index_i,
  input  wire logic [PIECE_W-1:0] piece_index_i,

  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [PRI_W-1:0]        piece_priority_o,
  output logic [PIECE_W-1:0]      first_piece_o,
  output logic [PIECE_W-1:0]      last_piece_o,
  output logic [FIDX_W-1:0]       assigned_index_o,

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [PSIZE_W-1:0] cfg_piece_size_i
);

  localparam int unsigned IDX_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FILES + 1);
  // Widths wide enough to compare or truncate across the fixed port widths.
  localparam int unsigned SUM_W = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
  localparam int unsigned QX_W  = (OFFSET_BITS > PIECE_W) ? OFFSET_BITS : PIECE_W;
  localparam int unsigned FX_W  = (CNT_W > FIDX_W) ? CNT_W : FIDX_W;

  // Control state.
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [PSIZE_W-1:0]   psize_q, psize_d;
  logic                 out_valid_q, out_valid_d;
  logic [CNT_W-1:0]     addr_q, addr_d;
  logic                 rd_vld_q, rd_vld_d;
  logic                 found_q, found_d;

  // Item and result payload.
  op_e                  op_q, op_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [PRI_W-1:0]     pri_q, pri_d;
  logic [FIDX_W-1:0]    fidx_q, fidx_d;
  logic [PIECE_W-1:0]   piece_q, piece_d;
  logic [PRI_W-1:0]     ppri_q, ppri_d;
  res_t                 res_q, res_d;
  res_t                 out_q, out_d;

  // Entry memories: piece span and priority, each one synchronous read port.
  logic [2*PIECE_W-1:0] piece_mem [MAX_FILES];
  logic [PRI_W-1:0]     pri_mem   [MAX_FILES];
  logic [2*PIECE_W-1:0] rd_piece_q;
  logic [PRI_W-1:0]     rd_pri_q;

  logic                 pm_we;
  logic [IDX_W-1:0]     pm_waddr;
  logic [2*PIECE_W-1:0] pm_wdata;
  logic                 pr_we;
  logic [IDX_W-1:0]     pr_waddr;
  logic [PRI_W-1:0]     pr_wdata;
  logic                 rd_en;
  logic [IDX_W-1:0]     raddr;

  // Append arithmetic.
  logic [SUM_W-1:0]     end_sum;
  logic [LEN_W-1:0]     len_m1;
  logic [SUM_W-1:0]     last_sum;
  logic                 overflow;
  logic                 div_start;
  logic                 div_done_a, div_done_b;
  logic [OFFSET_BITS-1:0] quo_a, quo_b;
  logic [QX_W-1:0]      quo_a_ext, quo_b_ext;

  // Query walk.
  logic [PIECE_W-1:0]   rd_first, rd_last;
  logic                 touch;
  logic [PRI_W-1:0]     walk_pri;

  logic                 in_fire;
  logic                 slot_free;
  logic [FX_W-1:0]      aidx_ext;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;

  // The end offset must fit in OFFSET_BITS; a zero-length file sits on the
  // piece of its offset, so its last byte is the offset itself.
  assign end_sum   = SUM_W'(off_q) + SUM_W'(len_q);
  assign overflow  = |(end_sum >> OFFSET_BITS);
  assign len_m1    = (len_q == '0) ? '0 : len_q - LEN_W'(1);
  assign last_sum  = SUM_W'(off_q) + SUM_W'(len_m1);

  ppt_div #(.WIDTH(OFFSET_BITS)) u_div_first (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_q),
    .divisor_i  (psize_q),
    .done_o     (div_done_a),
    .quotient_o (quo_a)
  );

  ppt_div #(.WIDTH(OFFSET_BITS)) u_div_last (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (last_sum[OFFSET_BITS-1:0]),
    .divisor_i  (psize_q),
    .done_o     (div_done_b),
    .quotient_o (quo_b)
  );

  // Piece numbers are reported in 40 bits whatever the offset width.
  assign quo_a_ext = QX_W'(quo_a);
  assign quo_b_ext = QX_W'(quo_b);
  assign aidx_ext  = FX_W'(count_q);

  // The piece under test is compared with the entry read in the previous
  // cycle. A file touching the piece lends its priority; one of normal or
  // higher priority that starts or ends there makes the piece high.
  assign rd_first = rd_piece_q[2*PIECE_W-1:PIECE_W];
  assign rd_last  = rd_piece_q[PIECE_W-1:0];
  assign touch    = (rd_first <= piece_q) && (piece_q <= rd_last);

  always_comb begin
    walk_pri = (rd_pri_q > ppri_q) ? rd_pri_q : ppri_q;
    if (rd_pri_q >= PRI_NORMAL && (rd_first == piece_q || rd_last == piece_q)) begin
      walk_pri = PRI_HIGH;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    off_d       = off_q;
    psize_d     = cfg_valid_i ? cfg_piece_size_i : psize_q;
    out_valid_d = out_valid_q && !out_ready_i;
    addr_d      = addr_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    op_d        = op_q;
    len_d       = len_q;
    pri_d       = pri_q;
    fidx_d      = fidx_q;
    piece_d     = piece_q;
    ppri_d      = ppri_q;
    res_d       = res_q;
    out_d       = out_q;
    pm_we       = 1'b0;
    pm_waddr    = count_q[IDX_W-1:0];
    pm_wdata    = {quo_a_ext[PIECE_W-1:0], quo_b_ext[PIECE_W-1:0]};
    pr_we       = 1'b0;
    pr_waddr    = count_q[IDX_W-1:0];
    pr_wdata    = pri_q;
    rd_en       = 1'b0;
    raddr       = addr_q[IDX_W-1:0];
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = op_e'(operation_i);
          len_d   = file_length_i;
          // Priority code three counts as high.
          pri_d   = (file_priority_i > PRI_HIGH) ? PRI_HIGH : file_priority_i;
          fidx_d  = file_index_i;
          piece_d = piece_index_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d = '{status: STAT_OK, ppri: PRI_LOW, first_piece: '0,
                  last_piece: '0, aidx: '0};
        case (op_q)
          OP_CLEAR: begin
            count_d = '0;
            off_d   = '0;
            state_d = S_FINISH;
          end
          OP_APPEND: begin
            if (count_q >= CNT_W'(MAX_FILES)) begin
              res_d.status = STAT_FULL;
              state_d      = S_FINISH;
            end else if (overflow) begin
              res_d.status = STAT_OVERFLOW;
              state_d      = S_FINISH;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          OP_SET_PRI: begin
            if (FX_W'(fidx_q) >= FX_W'(count_q)) begin
              res_d.status = STAT_RANGE;
            end else begin
              pr_we    = 1'b1;
              pr_waddr = IDX_W'(fidx_q);
            end
            state_d = S_FINISH;
          end
          OP_QUERY: begin
            addr_d  = '0;
            found_d = 1'b0;
            ppri_d  = PRI_LOW;
            state_d = S_WALK;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end

      S_DIV: begin
        if (div_done_a) begin
          pm_we             = 1'b1;
          pr_we             = 1'b1;
          res_d.first_piece = quo_a_ext[PIECE_W-1:0];
          res_d.last_piece  = quo_b_ext[PIECE_W-1:0];
          res_d.aidx        = aidx_ext[FIDX_W-1:0];
          count_d           = count_q + CNT_W'(1);
          off_d             = end_sum[OFFSET_BITS-1:0];
          state_d           = S_FINISH;
        end
      end

      S_WALK: begin
        // Reads go out one per cycle; each is judged in the cycle after it.
        if (addr_q < count_q) begin
          rd_en    = 1'b1;
          addr_d   = addr_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          if (touch) begin
            found_d = 1'b1;
            ppri_d  = walk_pri;
          end else if (found_q) begin
            // The run of touching entries has ended.
            res_d.ppri = ppri_q;
            rd_vld_d   = 1'b0;
            state_d    = S_FINISH;
          end
        end else if (addr_q >= count_q) begin
          res_d.ppri = ppri_q;
          state_d    = S_FINISH;
        end
      end

      S_FINISH: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      off_q       <= '0;
      psize_q     <= PSIZE_RESET;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      off_q       <= off_d;
      psize_q     <= psize_d;
      out_valid_q <= out_valid_d;
      addr_q      <= addr_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    len_q   <= len_d;
    pri_q   <= pri_d;
    fidx_q  <= fidx_d;
    piece_q <= piece_d;
    ppri_q  <= ppri_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // Writes and reads of one entry never fall in the same item, since a single
  // item is in work at a time, so the memories need no forwarding.
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      piece_mem[pm_waddr] <= pm_wdata;
    end
    if (rd_en) begin
      rd_piece_q <= piece_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pr_we) begin
      pri_mem[pr_waddr] <= pr_wdata;
    end
    if (rd_en) begin
      rd_pri_q <= pri_mem[raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign piece_priority_o = out_q.ppri;
  assign first_piece_o    = out_q.first_piece;
  assign last_piece_o     = out_q.last_piece;
  assign assigned_index_o = out_q.aidx;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_done_a == div_done_b))
    else $error("piece dividers out of step");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && rd_vld_q) |-> ($past(addr_q) < count_q))
    else $error("query read beyond stored entries");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && !out_ready_i) |=> (state_q == S_FINISH))
    else $error("result left while output register busy");

  a_append_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done_a) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("append did not advance the entry count");

endmodule

`default_nettype wire

// File: rtl/ppt_div.sv
// Restoring divider, one quotient bit per cycle, for byte offset / piece size.
// Depends on ppt_pkg for the divisor width.
`default_nettype none

module ppt_div
  import ppt_pkg::*;
#(
  parameter int unsigned WIDTH = 40
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [WIDTH-1:0]   dividend_i,
  input  wire logic [PSIZE_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [WIDTH-1:0]        quotient_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [WIDTH-1:0]   quo_q, quo_d;
  logic [PSIZE_W-1:0] rem_q, rem_d;
  logic [PSIZE_W-1:0] dvs_q, dvs_d;

  logic [PSIZE_W:0]   trial;
  logic [PSIZE_W:0]   diff;
  logic               ge;

  always_comb begin
    trial  = {rem_q, quo_q[WIDTH-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH);
      quo_d  = dividend_i;
      rem_d  = '0;
      // A piece size of zero divides as one.
      dvs_d  = (divisor_i == '0) ? PSIZE_W'(1) : divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[WIDTH-2:0], ge};
      rem_d = ge ? diff[PSIZE_W-1:0] : trial[PSIZE_W-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with no steps left");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for piece_priority_table: sends clear, append, set and
// query beats, predicts every result beat and compares it field by field.
// Depends on ppt_pkg and the piece_priority_table RTL, nothing else.

module tb_top;
  import ppt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam logic [PIECE_W-1:0] OFFSET_LIMIT = '1;

  // Clock, reset and every block input start at a known value.
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic [1:0]         operation_i      = OP_CLEAR;
  logic [LEN_W-1:0]   file_length_i    = '0;
  logic [PRI_W-1:0]   file_priority_i  = '0;
  logic [FIDX_W-1:0]  file_index_i     = '0;
  logic [PIECE_W-1:0] piece_index_i    = '0;
  logic               out_ready_i      = 1'b0;
  logic               cfg_valid_i      = 1'b0;
  logic [PSIZE_W-1:0] cfg_piece_size_i = '0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic [PRI_W-1:0]   piece_priority_o;
  logic [PIECE_W-1:0] first_piece_o;
  logic [PIECE_W-1:0] last_piece_o;
  logic [FIDX_W-1:0]  assigned_index_o;
  logic               cfg_ready_o;

  // Mirror of the file table as the block should hold it. Only entries below
  // file_count are ever read, exactly as in the block.
  logic [PIECE_W-1:0] file_first_piece [TABLE_DEPTH];
  logic [PIECE_W-1:0] file_last_piece  [TABLE_DEPTH];
  logic [PRI_W-1:0]   file_pri         [TABLE_DEPTH];
  int unsigned        file_count  = 0;
  logic [PIECE_W-1:0] byte_offset = '0;
  logic [PSIZE_W-1:0] piece_bytes = PSIZE_RESET;

  // Results still owed by the block, oldest first.
  res_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned size_writes    = 0;

  // When set, both sides insert random idle bursts.
  bit          idle_bursts = 1'b0;
  int unsigned stall_left  = 0;

  piece_priority_table DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .file_length_i    (file_length_i),
    .file_priority_i  (file_priority_i),
    .file_index_i     (file_index_i),
    .piece_index_i    (piece_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .piece_priority_o (piece_priority_o),
    .first_piece_o    (first_piece_o),
    .last_piece_o     (last_piece_o),
    .assigned_index_o (assigned_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_piece_size_i (cfg_piece_size_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The effective divisor: a piece size of zero counts as one byte.
  function automatic logic [PIECE_W-1:0] piece_unit();
    return (piece_bytes == '0) ? 40'd1 : 40'(piece_bytes);
  endfunction

  function automatic bit touches_piece(int unsigned k, logic [PIECE_W-1:0] piece);
    return file_first_piece[k] <= piece && piece <= file_last_piece[k];
  endfunction

  // Applies one accepted beat to the mirrored table and returns the result
  // the block must produce for it.
  function automatic res_t predict_result(op_e op, logic [LEN_W-1:0] len,
                                          logic [PRI_W-1:0] pri_in,
                                          logic [FIDX_W-1:0] fidx,
                                          logic [PIECE_W-1:0] piece);
    res_t               r;
    logic [PRI_W-1:0]   pri;
    logic [PRI_W-1:0]   found;
    logic [PIECE_W-1:0] last_byte;
    int unsigned        k;
    r = '0;
    r.status = STAT_OK;
    // Priority code three is taken as high.
    pri = (pri_in > PRI_HIGH) ? PRI_HIGH : pri_in;
    case (op)
      OP_CLEAR: begin
        file_count  = 0;
        byte_offset = '0;
      end
      OP_APPEND: begin
        // A full table wins over an offset overflow.
        if (file_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else if (len > OFFSET_LIMIT - byte_offset) begin
          r.status = STAT_OVERFLOW;
        end else begin
          // A zero-length file covers the piece that holds its offset.
          last_byte = byte_offset + ((len != '0) ? len - 40'd1 : 40'd0);
          r.first_piece = byte_offset / piece_unit();
          r.last_piece  = last_byte / piece_unit();
          r.aidx        = file_count[FIDX_W-1:0];
          file_first_piece[file_count] = r.first_piece;
          file_last_piece[file_count]  = r.last_piece;
          file_pri[file_count]         = pri;
          file_count++;
          byte_offset += len;
        end
      end
      OP_SET_PRI: begin
        if (fidx >= file_count) begin
          r.status = STAT_RANGE;
        end else begin
          file_pri[fidx] = pri;
        end
      end
      default: begin
        // The walk starts at the lowest entry touching the piece and stops at
        // the first following entry that does not, so later entries written
        // under another piece size may stay unseen.
        found = PRI_LOW;
        k = 0;
        while (k < file_count && !touches_piece(k, piece)) k++;
        while (k < file_count && touches_piece(k, piece)) begin
          if (file_pri[k] > found) found = file_pri[k];
          if (file_pri[k] >= PRI_NORMAL &&
              (file_first_piece[k] == piece || file_last_piece[k] == piece)) begin
            found = PRI_HIGH;
          end
          k++;
        end
        r.ppri = found;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the checker
  // ---------------------------------------------------------------------------

  // A stall is a random burst with ready low.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
      out_ready_i = 1'b0;
      stall_left  = $urandom_range(1, 16) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  function automatic void check_field(string field, logic [PIECE_W-1:0] got,
                                      logic [PIECE_W-1:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual status %0d",
                 $time, status_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        check_field("status", 40'(status_o), 40'(want.status));
        check_field("piece_priority", 40'(piece_priority_o), 40'(want.ppri));
        check_field("first_piece", first_piece_o, want.first_piece);
        check_field("last_piece", last_piece_o, want.last_piece);
        check_field("assigned_index", 40'(assigned_index_o), 40'(want.aidx));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item side
  // ---------------------------------------------------------------------------

  // Sends one beat and predicts its result when it is accepted. Valid stays
  // high on return, so the caller must either send again at once or call
  // wait_drain, which lowers it.
  task automatic send_item(op_e op, logic [LEN_W-1:0] len, logic [PRI_W-1:0] pri,
                           logic [FIDX_W-1:0] fidx, logic [PIECE_W-1:0] piece);
    int unsigned gap;
    gap = 0;
    if (idle_bursts && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    operation_i     = op;
    file_length_i   = len;
    file_priority_i = pri;
    file_index_i    = fidx;
    piece_index_i   = piece;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_result(op, len, pri, fidx, piece));
    items_sent++;
  endtask

  // Lowers valid and holds off until every owed result has been seen.
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Piece size writes happen only with the block idle.
  task automatic write_piece_size(logic [PSIZE_W-1:0] value);
    wait_drain();
    repeat (4) @(negedge clk_i);
    cfg_valid_i      = 1'b1;
    cfg_piece_size_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    piece_bytes = value;
    size_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [PIECE_W-1:0] random_bits40();
    return 40'({$urandom(), $urandom()});
  endfunction

  function automatic logic [PRI_W-1:0] random_pri();
    return 2'($urandom_range(0, 3));
  endfunction

  // Lengths mostly near the piece size so files share and straddle pieces;
  // a few fill or overflow the byte space.
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 15))
      0, 1:          return '0;
      2, 3, 4, 5:    return 40'($urandom_range(1, 3)) * piece_unit() +
                            40'($urandom_range(0, 2)) - 40'd1;
      6, 7, 8, 9:    return 40'($urandom_range(1, 32'(piece_unit())));
      10:            return random_bits40();
      11:            return OFFSET_LIMIT - byte_offset + 40'($urandom_range(0, 1));
      default:       return 40'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  // Queried pieces sit mostly on, next to or inside the stored files.
  function automatic logic [PIECE_W-1:0] pick_piece();
    int unsigned k;
    logic [63:0] span;
    span = 64'(byte_offset / piece_unit()) + 64'd2;
    if (file_count != 0) begin
      k = $urandom_range(0, file_count - 1);
      case ($urandom_range(0, 7))
        0: return random_bits40();
        1, 2: return file_first_piece[k] - 40'($urandom_range(0, 1));
        3, 4: return file_last_piece[k] + 40'($urandom_range(0, 1));
        default: ;
      endcase
    end
    return 40'(64'({$urandom(), $urandom()}) % span);
  endfunction

  function automatic logic [FIDX_W-1:0] pick_file_index();
    if (file_count != 0 && $urandom_range(0, 3) != 0) begin
      return 8'($urandom_range(0, file_count - 1));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // One well-formed burst of work: maybe a clear, a few appends, a few
  // priority changes and a few queries, all with random content.
  task automatic run_file_sequence();
    int unsigned n;
    int unsigned files;
    if ($urandom_range(0, 2) == 0) begin
      send_item(OP_CLEAR, random_bits40(), random_pri(), 8'($urandom()), random_bits40());
    end
    files = $urandom_range(1, 8);
    for (n = 0; n < files; n++) begin
      send_item(OP_APPEND, pick_length(), random_pri(), 8'($urandom()), random_bits40());
    end
    repeat ($urandom_range(0, 3)) begin
      send_item(OP_SET_PRI, random_bits40(), random_pri(), pick_file_index(),
                random_bits40());
    end
    repeat ($urandom_range(2, 6)) begin
      send_item(OP_QUERY, random_bits40(), random_pri(), 8'($urandom()), pick_piece());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation at the reset piece size, the empty table, priority code
  // three, zero-length files and the very ends of the byte space.
  task automatic test_basic_ops();
    send_item(OP_QUERY, '0, '0, '0, '0);
    send_item(OP_SET_PRI, '0, PRI_HIGH, 8'd0, '0);
    send_item(OP_APPEND, '0, PRI_NORMAL, '0, '0);
    send_item(OP_APPEND, 40'd1, 2'd3, '0, '0);
    send_item(OP_APPEND, 40'd524293, PRI_NORMAL, '0, '0);
    send_item(OP_SET_PRI, '0, PRI_LOW, 8'd1, '0);
    send_item(OP_SET_PRI, '0, PRI_NORMAL, 8'd3, '0);
    send_item(OP_SET_PRI, '1, 2'd3, 8'hFF, '1);
    send_item(OP_QUERY, '0, '0, '0, 40'd0);
    send_item(OP_QUERY, '0, '0, '0, 40'd1);
    send_item(OP_QUERY, '0, '0, '0, 40'd2);
    send_item(OP_QUERY, '0, '0, '0, 40'd3);
    send_item(OP_CLEAR, '1, '1, '1, '1);
    send_item(OP_QUERY, '0, '0, '0, '0);
    // The largest file fills the byte space; after it only empty files fit.
    send_item(OP_APPEND, OFFSET_LIMIT, PRI_LOW, '0, '0);
    send_item(OP_APPEND, 40'd1, PRI_HIGH, '0, '0);
    send_item(OP_APPEND, '0, PRI_HIGH, '0, '0);
    send_item(OP_QUERY, '0, '0, '0, OFFSET_LIMIT);
    send_item(OP_QUERY, '0, '0, '0, OFFSET_LIMIT / 40'(PSIZE_RESET));
    send_item(OP_CLEAR, '0, '0, '0, '0);
  endtask

  // Files written under one piece size and then another: the query walk may
  // stop before entries it would otherwise reach. A zero size acts as one.
  task automatic test_piece_size_walk();
    write_piece_size(25'd1);
    send_item(OP_APPEND, 40'd10, PRI_LOW, '0, '0);
    send_item(OP_APPEND, 40'd10, PRI_NORMAL, '0, '0);
    write_piece_size(25'd4);
    send_item(OP_APPEND, 40'd8, PRI_HIGH, '0, '0);
    send_item(OP_QUERY, '0, '0, '0, 40'd5);
    send_item(OP_QUERY, '0, '0, '0, 40'd6);
    send_item(OP_QUERY, '0, '0, '0, 40'd10);
    write_piece_size(25'd0);
    send_item(OP_APPEND, 40'd3, PRI_NORMAL, '0, '0);
    send_item(OP_QUERY, '0, '0, '0, 40'd29);
    send_item(OP_CLEAR, '0, '0, '0, '0);
  endtask

  // Fills all entries, then tries one more append and queries a piece that
  // every entry touches, so the walk runs over the whole table.
  task automatic test_table_full();
    int unsigned n;
    write_piece_size(25'h1FF_FFFF);
    for (n = 0; n < TABLE_DEPTH; n++) begin
      send_item(OP_APPEND, 40'($urandom_range(0, 3)), random_pri(), '0, '0);
      // The sender once holds back until the block has answered everything.
      if (n == TABLE_DEPTH / 2) wait_drain();
    end
    send_item(OP_APPEND, OFFSET_LIMIT, PRI_HIGH, '0, '0);
    send_item(OP_SET_PRI, '0, PRI_HIGH, 8'hFF, '0);
    send_item(OP_QUERY, '0, '0, '0, '0);
    send_item(OP_QUERY, '0, '0, '0, 40'd1);
    send_item(OP_CLEAR, '0, '0, '0, '0);
  endtask

  // Random traffic in six phases, each under its own piece size. Mostly
  // well-formed sequences; each step is a fully random beat with chance one in five.
  task automatic test_random_traffic();
    logic [PSIZE_W-1:0] sizes [6];
    int unsigned phase;
    int unsigned first_item;
    sizes = '{25'd16777216, 25'd262144, 25'($urandom_range(2, 4096)), 25'd1,
              25'($urandom_range(1, 25'h1FF_FFFF)), 25'($urandom_range(2, 64))};
    for (phase = 0; phase < 6; phase++) begin
      write_piece_size(sizes[phase]);
      // Phase one runs without idling; the last phase too.
      idle_bursts = (phase != 1) && (phase != 5);
      first_item = items_sent;
      while (items_sent - first_item < 50) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(op_e'($urandom_range(0, 3)), random_bits40(), random_pri(),
                    8'($urandom()), random_bits40());
        end else begin
          run_file_sequence();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idle_bursts = 1'b1;

    test_basic_ops();
    test_piece_size_walk();
    test_table_full();
    test_random_traffic();

    // Longest item is a query over a full table.
    wait_drain();
    repeat (300) @(posedge clk_i);

    $display("Ran %0d item beats and checked %0d result beats under %0d piece size writes,",
             items_sent, results_seen, size_writes);
    $display("covering full table, offset overflow, bad indexes and cut-short walks.");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A correct run needs well under 10 ms of simulated time.
  initial begin
    #40_000_000;
    $display("%0t: timeout with %0d results still owed", $time, pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
